// ===== src/tsq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsq_pkg: shared types and constants of the two-stack queue
// Sizes, operation and status codes, controller states, and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package tsq_pkg;

  // Entries in each stack.
  localparam int DEPTH  = 128;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  // Operation codes carried on the input selector.
  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  // Kind of result the datapath builds when it loads the output register.
  typedef enum logic [1:0] {
    RSP_ENQ   = 2'd0,
    RSP_NOP   = 2'd1,
    RSP_EMPTY = 2'd2,
    RSP_TOP   = 2'd3
  } rsp_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MOVE,
    S_TOPRD,
    S_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // capture the incoming item
    logic enq_push;  // write the held value on top of the input stack
    logic move_rd;   // pop the input stack top into the transfer register
    logic move_wr;   // push the transfer register onto the output stack
    logic top_rd;    // read the output stack top
    logic pop;       // drop the output stack top
    logic load_out;  // load the result register
    rsp_t rsp;       // kind of result to load
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;        // opcode of the held item
    logic in_zero;   // input stack is empty
    logic in_full;   // input stack holds DEPTH entries
    logic out_zero;  // output stack is empty
    logic out_free;  // result register can take a new result
  } sts_t;

endpackage

// ===== src/tsq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsq_ctrl: queue operation sequencer
// Steps one item at a time through enqueue, refill of the output stack,
// top read and result hand-off, driving the datapath by commands.
// ----------------------------------------------------------------------------
module tsq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  tsq_pkg::sts_t sts,
  output tsq_pkg::cmd_t cmd
);
  import tsq_pkg::*;

  state_t state, state_next;
  logic   pend, pend_next;   // a popped entry waits in the transfer register

  // State and transfer-pending registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next   = state;
    pend_next    = 1'b0;
    s_tready     = 1'b0;
    cmd          = '0;
    cmd.rsp      = RSP_NOP;
    case (state)
      S_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.op == OP_DEQ || sts.op == OP_PEEK) begin
          if (!sts.out_zero) begin
            state_next = S_TOPRD;
          end else if (!sts.in_zero) begin
            state_next = S_MOVE;
          end else if (sts.out_free) begin
            cmd.load_out = 1'b1;
            cmd.rsp      = RSP_EMPTY;
            state_next   = S_IDLE;
          end
        end else if (sts.out_free) begin
          cmd.load_out = 1'b1;
          if (sts.op == OP_ENQ) begin
            cmd.enq_push = !sts.in_full;
            cmd.rsp      = RSP_ENQ;
          end else begin
            cmd.rsp = RSP_NOP;
          end
          state_next = S_IDLE;
        end
      end
      // Pop the input stack and push onto the output stack, one entry a
      // cycle, each read held in the transfer register and written the cycle after.
      S_MOVE: begin
        cmd.move_rd = !sts.in_zero;
        cmd.move_wr = pend;
        pend_next   = !sts.in_zero;
        if (sts.in_zero) begin
          state_next = S_TOPRD;
        end
      end
      S_TOPRD: begin
        cmd.top_rd = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.rsp      = RSP_TOP;
          cmd.pop      = (sts.op == OP_DEQ);
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/tsq_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsq_dp: stack memories, counters and result register
// Holds the input and output stacks, their fill counts, the captured item
// and the registered result that faces the output channel.
// ----------------------------------------------------------------------------
module tsq_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [1:0]                    s_tuser,
  input  logic [tsq_pkg::DATA_W-1:0]    s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [tsq_pkg::DATA_W-1:0]    m_tdata,
  output logic [2:0]                    m_tuser,
  input  tsq_pkg::cmd_t                 cmd,
  output tsq_pkg::sts_t                 sts
);
  import tsq_pkg::*;

  logic [DATA_W-1:0] in_mem  [DEPTH];
  logic [DATA_W-1:0] out_mem [DEPTH];

  op_t               op;
  logic [DATA_W-1:0] val;
  logic [CNT_W-1:0]  in_count;
  logic [CNT_W-1:0]  out_count;
  logic [CNT_W-1:0]  in_m1;
  logic [CNT_W-1:0]  out_m1;
  logic [DATA_W-1:0] in_rdata;
  logic [DATA_W-1:0] out_rdata;
  logic [DATA_W-1:0] res_data;
  status_t           res_status;
  logic              res_empty;

  assign in_m1  = in_count - CNT_W'(1);
  assign out_m1 = out_count - CNT_W'(1);

  function automatic logic in_full_w();
    return in_count == CNT_W'(DEPTH);
  endfunction

  // Captured item.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op  <= op_t'(s_tuser);
      val <= s_tdata;
    end
  end

  // Input stack: pushed by enqueue, popped by the transfer.
  always_ff @(posedge clk) begin
    if (cmd.enq_push) begin
      in_mem[in_count[ADDR_W-1:0]] <= val;
    end
    if (cmd.move_rd) begin
      in_rdata <= in_mem[in_m1[ADDR_W-1:0]];
    end
  end

  // Output stack: pushed by the transfer, read at its top, popped by a dequeue.
  always_ff @(posedge clk) begin
    if (cmd.move_wr) begin
      out_mem[out_count[ADDR_W-1:0]] <= in_rdata;
    end
    if (cmd.top_rd) begin
      out_rdata <= out_mem[out_m1[ADDR_W-1:0]];
    end
  end

  // Fill counts.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_count  <= '0;
      out_count <= '0;
    end else begin
      if (cmd.enq_push) begin
        in_count <= in_count + CNT_W'(1);
      end else if (cmd.move_rd) begin
        in_count <= in_m1;
      end
      if (cmd.move_wr) begin
        out_count <= out_count + CNT_W'(1);
      end else if (cmd.pop) begin
        out_count <= out_m1;
      end
    end
  end

  // Result fields; the empty flag describes the stacks after the operation.
  always_comb begin
    res_data   = '0;
    res_status = ST_OK;
    res_empty  = 1'b0;
    case (cmd.rsp)
      RSP_ENQ: begin
        res_status = in_full_w() ? ST_FULL : ST_OK;
      end
      RSP_NOP: begin
        res_empty = (in_count == '0) && (out_count == '0);
      end
      RSP_EMPTY: begin
        res_data   = '1;
        res_status = ST_EMPTY;
        res_empty  = 1'b1;
      end
      RSP_TOP: begin
        res_data  = out_rdata;
        res_empty = (op == OP_DEQ) && (out_count == CNT_W'(1)) && (in_count == '0);
      end
      default: begin
        res_data = '0;
      end
    endcase
  end

  // Result register facing the output channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= res_data;
      m_tuser <= {res_empty, res_status};
    end
  end

  // Status toward the controller.
  assign sts.op       = op;
  assign sts.in_zero  = (in_count == '0);
  assign sts.in_full  = in_full_w();
  assign sts.out_zero = (out_count == '0);
  assign sts.out_free = !m_tvalid || m_tready;

endmodule

// ===== src/two_stack_fifo_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_stack_fifo_queue: first-in first-out queue built from two stacks
// Input items carry an operation (enqueue, dequeue, peek) on s_tuser and a
// value on s_tdata; every item gives exactly one result item on the master
// side. Results appear in order of the input items.
// Sequence: an enqueue or an item that finds the queue empty is answered
// from the execute state; a dequeue or peek that finds the output stack
// filled goes on through the top read and the result state. When the output
// stack is empty and the input stack holds entries, a refill first moves
// every entry across through the transfer register. One item is in work at
// a time; the input is ready again in the cycle after the result is loaded.
// The result sits in an output register, so a new item may be accepted
// while the previous result still waits; a stalled receiver holds the
// result and blocks the loading of the next one, and with it the input.
// Reset clears both fill counts and the result valid flag; stack contents are
// not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module two_stack_fifo_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] data_in
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] data_out
  output logic [2:0]  m_tuser    // [1:0] status, [2] queue_empty
);
  import tsq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Operation sequencer.
  tsq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Stacks, counters and result register.
  tsq_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .sts      (sts)
  );

`ifndef SYNTH
  // Only one item is in work: an accepted item closes the input.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an item is in work");

  // A result never overwrites one that has not been taken.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded over a pending result");

  // The transfer only pops a non-empty input stack.
  a_move_src: assert property (@(posedge clk) disable iff (rst)
    cmd.move_rd |-> !sts.in_zero)
    else $error("transfer read from an empty input stack");

  // The top of the output stack is read only when it holds an entry.
  a_top_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.top_rd |-> !sts.out_zero)
    else $error("top read from an empty output stack");
`endif

endmodule

// ===== bench/queue_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// queue_result_checker: result predictor and comparator for the two-stack queue
// Watches both stream channels of the queue. Every accepted input item is run
// through a private copy of the two stacks to work out the result it must
// give. Every accepted result item is compared field by field with the oldest
// prediction. Mismatch and activity counts are handed to the testbench top.
// ----------------------------------------------------------------------------
module queue_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] data_in
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // [31:0] data_out
  input  logic [2:0]  m_tuser,   // [1:0] status, [2] queue_empty
  output int          fail_count,
  output int          pending,
  output int          result_count,
  output int          drop_count,
  output int          empty_count,
  output int          refill_count
);
  import tsq_pkg::*;

  // One predicted result item.
  typedef struct packed {
    logic [31:0] data;
    status_t     status;
    logic        empty;
  } queue_result_t;

  // Private copy of the queue state.
  logic [31:0] in_stack_copy  [DEPTH];
  logic [31:0] out_stack_copy [DEPTH];
  int unsigned in_fill;
  int unsigned out_fill;

  queue_result_t expected_results [$];
  queue_result_t oldest;

  int mismatches = 0;
  int results    = 0;
  int drops      = 0;
  int empties    = 0;
  int refills    = 0;

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("queue_result_checker: %0t ns: %s: got %h, expected %h",
             $time, what, got, want);
    mismatches++;
  endtask

  // Apply one operation to the state copy and return the result it gives.
  function automatic queue_result_t apply_queue_op(input op_t op,
                                                   input logic [31:0] value);
    queue_result_t r;
    r.data   = '0;
    r.status = ST_OK;
    case (op)
      OP_ENQ: begin
        // A full input stack drops the value, even if the output stack has room.
        if (in_fill >= DEPTH) begin
          r.status = ST_FULL;
          drops++;
        end else begin
          in_stack_copy[in_fill] = value;
          in_fill++;
        end
      end
      OP_DEQ, OP_PEEK: begin
        // An empty output stack takes over the whole input stack, reversed.
        if (out_fill == 0 && in_fill != 0) begin
          refills++;
          while (in_fill > 0 && out_fill < DEPTH) begin
            in_fill--;
            out_stack_copy[out_fill] = in_stack_copy[in_fill];
            out_fill++;
          end
        end
        if (out_fill == 0) begin
          r.data   = '1;
          r.status = ST_EMPTY;
          empties++;
        end else begin
          r.data = out_stack_copy[out_fill - 1];
          if (op == OP_DEQ) out_fill--;
        end
      end
      default: ;
    endcase
    r.empty = (in_fill == 0 && out_fill == 0);
    return r;
  endfunction

  // Compare results first, then predict for a newly accepted item.
  always @(posedge clk) begin
    if (rst) begin
      in_fill  = 0;
      out_fill = 0;
      expected_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        results++;
        if (expected_results.size() == 0) begin
          report_mismatch("result item with no prediction waiting", m_tdata, '0);
        end else begin
          oldest = expected_results.pop_front();
          if (m_tdata !== oldest.data)
            report_mismatch("data_out", m_tdata, oldest.data);
          if (m_tuser[1:0] !== oldest.status)
            report_mismatch("status", 32'(m_tuser[1:0]), 32'(oldest.status));
          if (m_tuser[2] !== oldest.empty)
            report_mismatch("queue_empty", 32'(m_tuser[2]), 32'(oldest.empty));
        end
      end
      if (s_tvalid && s_tready)
        expected_results.push_back(apply_queue_op(op_t'(s_tuser), s_tdata));
    end
    fail_count   <= mismatches;
    pending      <= expected_results.size();
    result_count <= results;
    drop_count   <= drops;
    empty_count  <= empties;
    refill_count <= refills;
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the two-stack queue
// Drives a short directed sequence through the empty, refill and mixed cases,
// then random bursts of enqueues, drains and mixed operations under three
// idling patterns, including a fill past full and a long receiver stall. The
// checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_top;
  import tsq_pkg::*;

  localparam int RESET_CYCLES   = 6;
  localparam int FILL_ITEMS     = DEPTH + 4;
  localparam int PHASE_ITEMS    = 180;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 20;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DIRECTED_ITEMS = 22;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = OP_NOP;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [2:0]  m_tuser;

  int fail_count;
  int pending;
  int result_count;
  int drop_count;
  int empty_count;
  int refill_count;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int ops_sent [4]  = '{0, 0, 0, 0};
  int stall_cycles  = 0;

  // Receiver hold-off is requested by flipping hold_flip.
  logic hold_flip = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  // Directed sequence: empty reads, extreme values, refill, mixed ops.
  op_t dir_op [DIRECTED_ITEMS] = '{
    OP_DEQ, OP_PEEK, OP_NOP, OP_ENQ, OP_ENQ, OP_ENQ, OP_ENQ, OP_NOP,
    OP_PEEK, OP_PEEK, OP_DEQ, OP_ENQ, OP_ENQ, OP_DEQ, OP_DEQ, OP_DEQ,
    OP_PEEK, OP_DEQ, OP_DEQ, OP_DEQ, OP_ENQ, OP_DEQ
  };
  logic [31:0] dir_val [DIRECTED_ITEMS] = '{
    32'h1234_5678, 32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF,
    32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hDEAD_BEEF,
    32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h0000_0001, 32'h5555_5555,
    32'hAAAA_AAAA, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
    32'hFFFF_FFFF, 32'h0000_0000, 32'h3333_3333, 32'hCCCC_CCCC,
    32'h0000_0001, 32'h8000_0000
  };

  two_stack_fifo_queue dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  queue_result_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count),
    .drop_count   (drop_count),
    .empty_count  (empty_count),
    .refill_count (refill_count)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: random ready, or held low for a long stretch on request.
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      hold_seen =  hold_flip;
      hold_left =  0;
    end else begin
      if (hold_flip != hold_seen) begin
        hold_seen = hold_flip;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: too long without any item moving on either side ends the run.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: timeout after %0d cycles with no item accepted", stall_cycles);
      $display("tb_top: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offer one item, with random idle cycles first; returns at acceptance.
  task automatic send_item(input op_t op, input logic [31:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    ops_sent[op]++;
  endtask

  // Wait until every predicted result has been accepted.
  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Values lean on the extremes now and then.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Burst kinds: 0-2 enqueue run, 3-4 drain run, otherwise mixed.
  function automatic op_t pick_op(input int kind);
    int roll;
    roll = $urandom_range(0, 99);
    if (kind <= 2) return OP_ENQ;
    if (kind <= 4) return (roll < 10) ? OP_PEEK : OP_DEQ;
    if (roll < 45) return OP_ENQ;
    if (roll < 80) return OP_DEQ;
    if (roll < 95) return OP_PEEK;
    return OP_NOP;
  endfunction

  // Random bursts until n_items have been accepted.
  task automatic run_random(input int n_items);
    int sent;
    int kind;
    int len;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      len  = $urandom_range(1, 16);
      for (int i = 0; i < len && sent < n_items; i++) begin
        send_item(pick_op(kind), pick_value());
        sent++;
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ITEMS; i++) send_item(dir_op[i], dir_val[i]);

    // Sender idles more rarely than the receiver. Fill past full, then stall
    // the receiver while items keep coming.
    send_idle_pct =  37;
    recv_idle_pct <= 56;
    for (int i = 0; i < FILL_ITEMS; i++) send_item(OP_ENQ, pick_value());
    hold_flip <= ~hold_flip;
    run_random(PHASE_ITEMS - FILL_ITEMS);
    s_tvalid <= 1'b0;
    wait_drained();

    // Roles swapped.
    send_idle_pct =  56;
    recv_idle_pct <= 37;
    run_random(PHASE_ITEMS);

    // No idling on either side.
    send_idle_pct =  0;
    recv_idle_pct <= 0;
    run_random(PHASE_ITEMS);
    s_tvalid <= 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);

    $display("tb_top: %0d items sent (enq %0d, deq %0d, peek %0d, nop %0d), %0d results checked",
             ops_sent[OP_ENQ] + ops_sent[OP_DEQ] + ops_sent[OP_PEEK] + ops_sent[OP_NOP],
             ops_sent[OP_ENQ], ops_sent[OP_DEQ], ops_sent[OP_PEEK], ops_sent[OP_NOP],
             result_count);
    $display("tb_top: %0d enqueues dropped when full, %0d reads of an empty queue, %0d refills",
             drop_count, empty_count, refill_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/tsq_pkg.sv
src/tsq_ctrl.sv
src/tsq_dp.sv
src/two_stack_fifo_queue.sv
bench/queue_result_checker.sv
bench/tb_top.sv
